// File: rtl/assert_macros.svh
// assertion macros used by the top-level classifier rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define HCLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define HCLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/hclc_pkg.sv
// shared types and constants of the hot/cold lru classifier
package hclc_pkg;

  localparam int HOT_DEPTH_DEF  = 64;
  localparam int COLD_DEPTH_DEF = 128;
  localparam int LBA_BITS_DEF   = 32;

  localparam int HOT_SIZE_W  = 7;
  localparam int COLD_SIZE_W = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [HOT_SIZE_W-1:0]  HOT_SIZE_RST  = 7'd3;
  localparam logic [COLD_SIZE_W-1:0] COLD_SIZE_RST = 8'd5;

  // register select, taken from the word address bit
  localparam logic REG_HOT_SIZE  = 1'b0;
  localparam logic REG_COLD_SIZE = 1'b1;

  typedef enum logic [2:0] {
    OUT_HOT_HIT  = 3'd0,
    OUT_COLD_HIT = 3'd1,
    OUT_MISS     = 3'd2,
    OUT_QUERY    = 3'd3,
    OUT_IGNORED  = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_MOVE_FRONT = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_INSERT     = 3'd3,
    OP_CLEAR      = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic     cmp_en;
    logic     key_nz;
    cell_op_t op;
  } cell_ctl_t;

endpackage

// File: rtl/hclc_pos_enc.sv
// one-hot match vector to slot index encoder
module hclc_pos_enc #(
  parameter int N = hclc_pkg::HOT_DEPTH_DEF,
  localparam int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]  onehot,
  output logic [IW-1:0] pos,
  output logic          any
);

  // at most one bit set, so an or of indexes gives the position
  always_comb begin
    pos = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        pos = pos | IW'(i);
      end
    end
  end

  assign any = |onehot;

endmodule

// File: rtl/hclc_cell.sv
// one list slot: holds an lba, compares it and shifts with its neighbors
module hclc_cell #(
  parameter int LBA_BITS = hclc_pkg::LBA_BITS_DEF,
  parameter int DEPTH    = hclc_pkg::HOT_DEPTH_DEF,
  parameter int IDX      = 0,
  localparam int SW = $clog2(DEPTH + 1),
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hclc_pkg::cell_ctl_t ctl,
  input  logic [SW-1:0]       size,
  input  logic [IW-1:0]       pos,
  input  logic [LBA_BITS-1:0] key,
  input  logic [LBA_BITS-1:0] left_val,
  input  logic [LBA_BITS-1:0] right_val,
  output logic [LBA_BITS-1:0] val,
  output logic                match,
  output logic [LBA_BITS-1:0] tail
);

  logic [LBA_BITS-1:0] val_r, val_nxt;
  logic                match_r;
  logic                in_range, is_last, ahead, behind;

  assign in_range = SW'(IDX) < size;
  assign is_last  = SW'(IDX + 1) == size;
  assign ahead    = IW'(IDX) <= pos;
  assign behind   = IW'(IDX) >= pos;

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.op)
      hclc_pkg::OP_HOLD: begin
      end
      hclc_pkg::OP_MOVE_FRONT: begin
        if (ahead) val_nxt = left_val;
      end
      hclc_pkg::OP_REMOVE: begin
        if (behind) val_nxt = right_val;
      end
      hclc_pkg::OP_INSERT: begin
        if (in_range) val_nxt = left_val;
      end
      hclc_pkg::OP_CLEAR: begin
        if (!in_range) val_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      match_r <= ctl.key_nz && (val_r == key);
    end
  end

  assign val   = val_r;
  assign match = match_r;
  assign tail  = is_last ? val_r : '0;

endmodule

// File: rtl/hot_cold_lru_classifier.sv
// top level: hot and cold lru lists built as chains of slot cells
// each request: cell compare step in S_CMP, then cell shift step in S_UPD, then the output register
// the shift step completes only when the output register is empty or its result is being taken
// the next request is taken in the shift step while the result goes into the output register
// reset (synchronous, active low) empties both lists and sets hot_size 3, cold_size 5
// no clearing pass: every slot cell is a resettable register
module hot_cold_lru_classifier #(
  parameter int HOT_DEPTH  = hclc_pkg::HOT_DEPTH_DEF,
  parameter int COLD_DEPTH = hclc_pkg::COLD_DEPTH_DEF,
  parameter int LBA_BITS   = hclc_pkg::LBA_BITS_DEF,
  localparam int IN_DW  = ((LBA_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((3 + 2 * LBA_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_DW-1:0]                in_tdata,   // lba
  input  logic                            in_tuser,   // mode
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_DW-1:0]               out_tdata,  // in_hot, demoted_valid,
                                                      // demoted_lba, evicted_valid,
                                                      // evicted_lba
  output logic [2:0]                      out_tuser,  // outcome
  // configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [hclc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [hclc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [hclc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

`include "assert_macros.svh"

  localparam int HSW = $clog2(HOT_DEPTH + 1);
  localparam int CSW = $clog2(COLD_DEPTH + 1);
  localparam int HIW = (HOT_DEPTH > 1) ? $clog2(HOT_DEPTH) : 1;
  localparam int CIW = (COLD_DEPTH > 1) ? $clog2(COLD_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [hclc_pkg::HOT_SIZE_W-1:0]  hot_size_r;
  logic [hclc_pkg::COLD_SIZE_W-1:0] cold_size_r;
  logic [hclc_pkg::HOT_SIZE_W-1:0]  hot_wdata;
  logic [hclc_pkg::COLD_SIZE_W-1:0] cold_wdata;
  logic                             cfg_wr, hot_wr, cold_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign hot_wr     = cfg_wr && (cfg_paddr[2] == hclc_pkg::REG_HOT_SIZE);
  assign cold_wr    = cfg_wr && (cfg_paddr[2] == hclc_pkg::REG_COLD_SIZE);
  assign hot_wdata  = cfg_pwdata[hclc_pkg::HOT_SIZE_W-1:0];
  assign cold_wdata = cfg_pwdata[hclc_pkg::COLD_SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_size_r  <= hclc_pkg::HOT_SIZE_RST;
      cold_size_r <= hclc_pkg::COLD_SIZE_RST;
    end else begin
      if (hot_wr)  hot_size_r  <= hot_wdata;
      if (cold_wr) cold_size_r <= cold_wdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == hclc_pkg::REG_HOT_SIZE)
                      ? hclc_pkg::CFG_DATA_W'(hot_size_r)
                      : hclc_pkg::CFG_DATA_W'(cold_size_r);

  // effective sizes: zero acts as one, large values saturate to the depth
  logic [HSW-1:0] hot_eff, hot_eff_new, hot_size_sel;
  logic [CSW-1:0] cold_eff, cold_eff_new, cold_size_sel;

  always_comb begin
    if (hot_size_r == '0) hot_eff = HSW'(1);
    else if (32'(hot_size_r) > 32'(HOT_DEPTH)) hot_eff = HSW'(HOT_DEPTH);
    else hot_eff = HSW'(hot_size_r);

    if (hot_wdata == '0) hot_eff_new = HSW'(1);
    else if (32'(hot_wdata) > 32'(HOT_DEPTH)) hot_eff_new = HSW'(HOT_DEPTH);
    else hot_eff_new = HSW'(hot_wdata);

    if (cold_size_r == '0) cold_eff = CSW'(1);
    else if (32'(cold_size_r) > 32'(COLD_DEPTH)) cold_eff = CSW'(COLD_DEPTH);
    else cold_eff = CSW'(cold_size_r);

    if (cold_wdata == '0) cold_eff_new = CSW'(1);
    else if (32'(cold_wdata) > 32'(COLD_DEPTH)) cold_eff_new = CSW'(COLD_DEPTH);
    else cold_eff_new = CSW'(cold_wdata);
  end

  // ---------------------------------------------------------------------
  // request capture and sequencing
  // ---------------------------------------------------------------------
  logic [LBA_BITS-1:0] lba_r;
  logic                mode_r;
  logic                in_fire, upd_go, lba_nz;
  logic                out_valid_r;

  // the shift cycle completes only when the output register can take the result
  assign upd_go    = (state_r == S_UPD) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE) || upd_go;
  assign in_fire   = in_tvalid && in_tready;
  assign lba_nz    = lba_r != '0;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lba_r  <= in_tdata[LBA_BITS-1:0];
      mode_r <= in_tuser;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_go) state_nxt = in_fire ? S_CMP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // cell chains
  // ---------------------------------------------------------------------
  logic [LBA_BITS-1:0] hot_val  [HOT_DEPTH];
  logic [LBA_BITS-1:0] hot_tv   [HOT_DEPTH];
  logic [LBA_BITS-1:0] cold_val [COLD_DEPTH];
  logic [LBA_BITS-1:0] cold_tv  [COLD_DEPTH];
  logic [HOT_DEPTH-1:0]  hot_match;
  logic [COLD_DEPTH-1:0] cold_match;
  logic [HIW-1:0]        hot_pos;
  logic [CIW-1:0]        cold_pos;
  logic                  hit_h, hit_c;

  hclc_pkg::cell_ctl_t hot_ctl, cold_ctl;
  logic [LBA_BITS-1:0] hot_ins, cold_ins;
  logic [LBA_BITS-1:0] hot_last, cold_last, hot_last_r, cold_last_r;

  for (genvar i = 0; i < HOT_DEPTH; i++) begin : g_hot
    logic [LBA_BITS-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = hot_ins;
    end else begin : g_mid
      assign left_v = hot_val[i-1];
    end
    if (i == HOT_DEPTH - 1) begin : g_end
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = hot_val[i+1];
    end
    hclc_cell #(
      .LBA_BITS(LBA_BITS),
      .DEPTH   (HOT_DEPTH),
      .IDX     (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (hot_ctl),
      .size     (hot_size_sel),
      .pos      (hot_pos),
      .key      (lba_r),
      .left_val (left_v),
      .right_val(right_v),
      .val      (hot_val[i]),
      .match    (hot_match[i]),
      .tail     (hot_tv[i])
    );
  end

  for (genvar i = 0; i < COLD_DEPTH; i++) begin : g_cold
    logic [LBA_BITS-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = cold_ins;
    end else begin : g_mid
      assign left_v = cold_val[i-1];
    end
    if (i == COLD_DEPTH - 1) begin : g_end
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = cold_val[i+1];
    end
    hclc_cell #(
      .LBA_BITS(LBA_BITS),
      .DEPTH   (COLD_DEPTH),
      .IDX     (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cold_ctl),
      .size     (cold_size_sel),
      .pos      (cold_pos),
      .key      (lba_r),
      .left_val (left_v),
      .right_val(right_v),
      .val      (cold_val[i]),
      .match    (cold_match[i]),
      .tail     (cold_tv[i])
    );
  end

  hclc_pos_enc #(.N(HOT_DEPTH)) u_hot_enc (
    .onehot(hot_match),
    .pos   (hot_pos),
    .any   (hit_h)
  );

  hclc_pos_enc #(.N(COLD_DEPTH)) u_cold_enc (
    .onehot(cold_match),
    .pos   (cold_pos),
    .any   (hit_c)
  );

  // last in-use slot of each list; only one cell drives a nonzero tail
  always_comb begin
    hot_last = '0;
    for (int i = 0; i < HOT_DEPTH; i++) hot_last = hot_last | hot_tv[i];
    cold_last = '0;
    for (int i = 0; i < COLD_DEPTH; i++) cold_last = cold_last | cold_tv[i];
  end

  // captured during the compare cycle, before any shift
  always_ff @(posedge clk) begin
    if (state_r == S_CMP) begin
      hot_last_r  <= hot_last;
      cold_last_r <= cold_last;
    end
  end

  // cell commands: compare in S_CMP, shift in S_UPD, trim on a size write
  always_comb begin
    hot_ctl.cmp_en  = state_r == S_CMP;
    hot_ctl.key_nz  = lba_nz;
    hot_ctl.op      = hclc_pkg::OP_HOLD;
    cold_ctl.cmp_en = state_r == S_CMP;
    cold_ctl.key_nz = lba_nz;
    cold_ctl.op     = hclc_pkg::OP_HOLD;
    hot_ins         = lba_r;
    cold_ins        = lba_r;
    hot_size_sel    = hot_eff;
    cold_size_sel   = cold_eff;

    if (hot_wr) begin
      hot_ctl.op   = hclc_pkg::OP_CLEAR;
      hot_size_sel = hot_eff_new;
    end
    if (cold_wr) begin
      cold_ctl.op   = hclc_pkg::OP_CLEAR;
      cold_size_sel = cold_eff_new;
    end

    if (upd_go && lba_nz && !mode_r) begin
      priority if (hit_h) begin
        // hot hit: slots up to the hit shift down, lba to the front
        hot_ctl.op = hclc_pkg::OP_MOVE_FRONT;
      end else if (hit_c) begin
        // cold hit: promote to hot front, hot tail goes to cold front
        hot_ctl.op = hclc_pkg::OP_INSERT;
        if (hot_last_r != '0) begin
          cold_ctl.op = hclc_pkg::OP_MOVE_FRONT;
          cold_ins    = hot_last_r;
        end else begin
          cold_ctl.op = hclc_pkg::OP_REMOVE;
        end
      end else begin
        // miss: insert at cold front, cold tail falls off
        cold_ctl.op = hclc_pkg::OP_INSERT;
      end
    end
  end

  // ---------------------------------------------------------------------
  // result
  // ---------------------------------------------------------------------
  hclc_pkg::outcome_t  res_outcome, out_outcome_r;
  logic                res_in_hot, res_dv, res_ev;
  logic [LBA_BITS-1:0] res_dl, res_el;
  logic                out_in_hot_r, out_dv_r, out_ev_r;
  logic [LBA_BITS-1:0] out_dl_r, out_el_r;

  always_comb begin
    res_outcome = hclc_pkg::OUT_IGNORED;
    res_in_hot  = 1'b0;
    res_dv      = 1'b0;
    res_dl      = '0;
    res_ev      = 1'b0;
    res_el      = '0;
    priority if (!lba_nz) begin
      res_outcome = hclc_pkg::OUT_IGNORED;
    end else if (mode_r) begin
      res_outcome = hclc_pkg::OUT_QUERY;
      res_in_hot  = hit_h;
    end else if (hit_h) begin
      res_outcome = hclc_pkg::OUT_HOT_HIT;
      res_in_hot  = 1'b1;
    end else if (hit_c) begin
      res_outcome = hclc_pkg::OUT_COLD_HIT;
      res_in_hot  = 1'b1;
      res_dv      = hot_last_r != '0;
      res_dl      = hot_last_r;
    end else begin
      res_outcome = hclc_pkg::OUT_MISS;
      res_ev      = cold_last_r != '0;
      res_el      = cold_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_outcome_r <= res_outcome;
      out_in_hot_r  <= res_in_hot;
      out_dv_r      <= res_dv;
      out_dl_r      <= res_dl;
      out_ev_r      <= res_ev;
      out_el_r      <= res_el;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_outcome_r;
  assign out_tdata  = OUT_DW'({out_el_r, out_ev_r, out_dl_r, out_dv_r, out_in_hot_r});

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `HCLC_ASSERT_IMP(a_hot_single, state_r == S_UPD, $onehot0(hot_match),
    "lba found in more than one hot slot")
  `HCLC_ASSERT_IMP(a_cold_single, state_r == S_UPD, $onehot0(cold_match),
    "lba found in more than one cold slot")
  `HCLC_ASSERT_IMP(a_lists_disjoint, state_r == S_UPD, !(hit_h && hit_c),
    "lba present in both hot and cold lists")
  `HCLC_ASSERT_IMP(a_demote_on_promote, out_valid_r && out_dv_r,
    out_outcome_r == hclc_pkg::OUT_COLD_HIT, "demotion without a cold hit")
  `HCLC_ASSERT_IMP(a_evict_on_miss, out_valid_r && out_ev_r,
    out_outcome_r == hclc_pkg::OUT_MISS, "eviction without a miss")

endmodule

// File: tb/sv/hclc_tb_pkg.sv
`timescale 1ns / 1ps
// scoreboard with its own lru predictor for the hot/cold classifier testbench
package hclc_tb_pkg;

  localparam int LBA_W = hclc_pkg::LBA_BITS_DEF;
  localparam int RES_W = ((3 + 2 * LBA_W + 7) / 8) * 8;

  localparam bit MODE_ACCESS = 1'b0;
  localparam bit MODE_QUERY  = 1'b1;

  typedef logic [LBA_W-1:0] lba_t;

  typedef struct {
    hclc_pkg::outcome_t outcome;
    bit                 in_hot;
    bit                 dem_v;
    lba_t               dem_lba;
    bit                 ev_v;
    lba_t               ev_lba;
  } lru_result_t;

  class lru_scoreboard;
    // lists hold only live entries, mru first
    lba_t                             hot_list[$];
    lba_t                             cold_list[$];
    logic [hclc_pkg::HOT_SIZE_W-1:0]  hot_reg;
    logic [hclc_pkg::COLD_SIZE_W-1:0] cold_reg;
    lru_result_t                      due_q[$];
    int                               errors;
    int                               tally[5];
    int                               demotions;
    int                               evictions;

    function new();
      hot_reg   = hclc_pkg::HOT_SIZE_RST;
      cold_reg  = hclc_pkg::COLD_SIZE_RST;
      errors    = 0;
      demotions = 0;
      evictions = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    static function int clamp_len(int raw, int depth);
      if (raw == 0) return 1;
      return (raw > depth) ? depth : raw;
    endfunction

    function int hot_limit();
      return clamp_len(hot_reg, hclc_pkg::HOT_DEPTH_DEF);
    endfunction

    function int cold_limit();
      return clamp_len(cold_reg, hclc_pkg::COLD_DEPTH_DEF);
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    static function int position_of(lba_t q[$], lba_t v);
      foreach (q[i]) if (q[i] == v) return i;
      return -1;
    endfunction

    function void set_size(logic sel, logic [hclc_pkg::CFG_DATA_W-1:0] word);
      if (sel == hclc_pkg::REG_HOT_SIZE) hot_reg = word[hclc_pkg::HOT_SIZE_W-1:0];
      else cold_reg = word[hclc_pkg::COLD_SIZE_W-1:0];
      // entries past a shrunk list are dropped
      while (hot_list.size() > hot_limit()) void'(hot_list.pop_back());
      while (cold_list.size() > cold_limit()) void'(cold_list.pop_back());
    endfunction

    function void note_request(bit mode, lba_t lba);
      lru_result_t r;
      int pos;
      r = '{outcome: hclc_pkg::OUT_IGNORED, in_hot: 1'b0, dem_v: 1'b0, dem_lba: '0,
            ev_v: 1'b0, ev_lba: '0};
      if (lba != '0) begin
        if (mode == MODE_QUERY) begin
          r.outcome = hclc_pkg::OUT_QUERY;
          r.in_hot  = position_of(hot_list, lba) >= 0;
        end else begin
          pos = position_of(hot_list, lba);
          if (pos >= 0) begin
            hot_list.delete(pos);
            hot_list.push_front(lba);
            r.outcome = hclc_pkg::OUT_HOT_HIT;
            r.in_hot  = 1'b1;
          end else begin
            pos = position_of(cold_list, lba);
            if (pos >= 0) begin
              // removal frees a cold slot, so a demotion never evicts
              cold_list.delete(pos);
              hot_list.push_front(lba);
              if (hot_list.size() > hot_limit()) begin
                r.dem_v   = 1'b1;
                r.dem_lba = hot_list.pop_back();
                cold_list.push_front(r.dem_lba);
              end
              r.outcome = hclc_pkg::OUT_COLD_HIT;
              r.in_hot  = 1'b1;
            end else begin
              cold_list.push_front(lba);
              if (cold_list.size() > cold_limit()) begin
                r.ev_v   = 1'b1;
                r.ev_lba = cold_list.pop_back();
              end
              r.outcome = hclc_pkg::OUT_MISS;
            end
          end
        end
      end
      due_q.push_back(r);
    endfunction

    function void field_check(string name, lba_t want, lba_t got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [RES_W-1:0] word);
      lru_result_t e;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: outcome %0d data %h", $time, kind, word);
        return;
      end
      e = due_q.pop_front();
      tally[int'(e.outcome)]++;
      demotions += e.dem_v;
      evictions += e.ev_v;
      field_check("outcome", lba_t'(e.outcome), lba_t'(kind));
      field_check("in_hot", lba_t'(e.in_hot), lba_t'(word[0]));
      field_check("demoted_valid", lba_t'(e.dem_v), lba_t'(word[1]));
      field_check("demoted_lba", e.dem_lba, word[2 +: LBA_W]);
      field_check("evicted_valid", lba_t'(e.ev_v), lba_t'(word[LBA_W+2]));
      field_check("evicted_lba", e.ev_lba, word[LBA_W+3 +: LBA_W]);
      field_check("pad bits", '0, lba_t'(word >> (2 * LBA_W + 3)));
    endfunction
  endclass

endpackage

// File: tb/sv/hot_cold_lru_classifier_tb.sv
`timescale 1ns / 1ps
// testbench top: drives requests and size writes into the classifier and checks every result
module hot_cold_lru_classifier_tb;

  localparam int IN_W        = ((hclc_tb_pkg::LBA_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 3000;  // cycles with no handshake on either channel
  localparam int PHASE_ITEMS = 166;   // non-zero requests per size setting
  localparam int NUM_PHASES  = 10;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [IN_W-1:0]                 in_tdata;    // lba
  logic                            in_tuser;    // mode
  logic                            out_tvalid;
  logic                            out_tready;
  logic [hclc_tb_pkg::RES_W-1:0]   out_tdata;   // in_hot, demoted_valid, demoted_lba,
                                                // evicted_valid, evicted_lba
  logic [2:0]                      out_tuser;   // outcome
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [hclc_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [hclc_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [hclc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  hclc_tb_pkg::lru_scoreboard sb;
  bit            idle_on;      // random gaps and stalls allowed
  int            stall_left;
  int            quiet_cycles;
  int            accepted;
  int            phases_done;

  hot_cold_lru_classifier dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: ready by default, dropped in random bursts while idling is on
  initial begin
    out_tready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  // every accepted result goes to the scoreboard, sampled at the edge
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request: valid stays up until the handshake edge
  task automatic send_request(bit mode, hclc_tb_pkg::lba_t lba);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= IN_W'(lba);
    do @(posedge clk); while (!in_tready);
    sb.note_request(mode, lba);
    accepted++;
  endtask

  // request, sometimes with a random gap in front of it while idling is on
  task automatic issue(bit mode, hclc_tb_pkg::lba_t lba);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    send_request(mode, lba);
  endtask

  // hold off the sender until every outstanding result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle; upper data bits are noise
  task automatic write_size(logic sel, int value);
    logic [hclc_pkg::CFG_DATA_W-1:0] word;
    word        = ($urandom & 32'hFFFF_FF00) | hclc_pkg::CFG_DATA_W'(value & 8'hFF);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= hclc_pkg::CFG_ADDR_W'({sel, 2'b00});
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_size(sel, word);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // apb read, compared with the stored register value
  task automatic check_size(logic sel);
    logic [hclc_pkg::CFG_DATA_W-1:0] want;
    logic [hclc_pkg::CFG_DATA_W-1:0] got;
    want        = (sel == hclc_pkg::REG_HOT_SIZE)
                  ? hclc_pkg::CFG_DATA_W'(sb.hot_reg)
                  : hclc_pkg::CFG_DATA_W'(sb.cold_reg);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= hclc_pkg::CFG_ADDR_W'({sel, 2'b00});
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got         = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== want) begin
      sb.errors++;
      $display("%0t: size register %0d readback: expected %h, actual %h",
               $time, sel, want, got);
    end
  endtask

  // directed walk at the reset sizes (hot 3, cold 5)
  task automatic run_directed();
    hclc_tb_pkg::lba_t pat[6];
    pat = '{32'h0000_0002, 32'h8000_0001, 32'h5555_AAAA,
            32'hAAAA_5555, 32'h0F0F_F0F0, 32'hF0F0_0F0F};
    // zero address is ignored in both modes
    issue(hclc_tb_pkg::MODE_ACCESS, '0);
    issue(hclc_tb_pkg::MODE_QUERY, '0);
    // query of an unknown address
    issue(hclc_tb_pkg::MODE_QUERY, pat[0]);
    // fill the cold list, then push its lru out
    for (int i = 0; i < 6; i++) issue(hclc_tb_pkg::MODE_ACCESS, pat[i]);
    // cold hit promotes, second access is a hot hit
    issue(hclc_tb_pkg::MODE_ACCESS, pat[1]);
    issue(hclc_tb_pkg::MODE_ACCESS, pat[1]);
    issue(hclc_tb_pkg::MODE_ACCESS, pat[2]);
    issue(hclc_tb_pkg::MODE_ACCESS, pat[3]);
    // hot list full: promotion demotes the hot lru into cold
    issue(hclc_tb_pkg::MODE_ACCESS, pat[4]);
    issue(hclc_tb_pkg::MODE_QUERY, pat[1]);
    issue(hclc_tb_pkg::MODE_QUERY, pat[3]);
    // hot hit on the lru entry at the end of the hot list
    issue(hclc_tb_pkg::MODE_ACCESS, pat[2]);
    // address extremes
    issue(hclc_tb_pkg::MODE_ACCESS, 32'h0000_0001);
    issue(hclc_tb_pkg::MODE_ACCESS, 32'hFFFF_FFFF);
    issue(hclc_tb_pkg::MODE_QUERY, 32'hFFFF_FFFF);
    issue(hclc_tb_pkg::MODE_ACCESS, 32'hFFFF_FFFF);
    issue(hclc_tb_pkg::MODE_ACCESS, pat[1]);
    issue(hclc_tb_pkg::MODE_QUERY, 32'hFFFF_FFFF);
  endtask

  // one size setting: write both registers while idle, then random traffic
  task automatic run_phase(int hot_v, int cold_v, bit calm);
    hclc_tb_pkg::lba_t pool[256];
    int                pool_n;
    int                sent;
    int                roll;
    int                idx;
    bit                paused;
    bit                mode;
    hclc_tb_pkg::lba_t lba;
    wait_drained();
    repeat (3) @(posedge clk);
    write_size(hclc_pkg::REG_HOT_SIZE, hot_v);
    write_size(hclc_pkg::REG_COLD_SIZE, cold_v);
    check_size(hclc_pkg::REG_HOT_SIZE);
    check_size(hclc_pkg::REG_COLD_SIZE);
    idle_on = !calm && ($urandom_range(0, 3) != 0);
    // address pool a bit larger than both lists together, so hits and evictions mix
    pool_n = sb.hot_limit() + sb.cold_limit() + $urandom_range(1, sb.hot_limit() + 4);
    if (pool_n > 256) pool_n = 256;
    for (int i = 0; i < pool_n; i++) begin
      do pool[i] = $urandom; while (pool[i] == '0);
    end
    sent   = 0;
    paused = 1'b0;
    while (sent < PHASE_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        mode = 1'($urandom_range(0, 1));
        lba  = '0;
      end else if (roll < 12) begin
        mode = 1'($urandom_range(0, 1));
        lba  = $urandom;
      end else begin
        // skewed pick: low pool entries recur often and turn hot
        idx  = $urandom_range(0, $urandom_range(0, pool_n - 1));
        lba  = pool[idx];
        mode = ($urandom_range(0, 4) == 0) ? hclc_tb_pkg::MODE_QUERY
                                           : hclc_tb_pkg::MODE_ACCESS;
      end
      issue(mode, lba);
      if (lba != '0) sent++;
      // sender holds off once per phase until the pipe is empty
      if (!paused && sent >= PHASE_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    phases_done++;
  endtask

  initial begin
    int hot_plan[NUM_PHASES];
    int cold_plan[NUM_PHASES];
    // sizes include zero (acts as 1), the depths and values above them
    hot_plan  = '{1, 0, 64, 127, 2, 16, 3, 8, 64, 1};
    cold_plan = '{1, 0, 128, 255, 3, 40, 5, 100, 1, 128};
    sb           = new();
    accepted     = 0;
    phases_done  = 0;
    idle_on      = 1'b1;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= 1'b0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    quiet_cycles <= 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // reset values of both size registers
    check_size(hclc_pkg::REG_HOT_SIZE);
    check_size(hclc_pkg::REG_COLD_SIZE);
    run_directed();
    // last phase runs with no idling on either side
    for (int p = 0; p < NUM_PHASES; p++) begin
      run_phase(hot_plan[p], cold_plan[p], p == NUM_PHASES - 1);
    end
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end
    $display("ran %0d requests across %0d size settings plus a directed walk",
             accepted, phases_done);
    $display("hot hits %0d, promotions %0d, misses %0d, queries %0d, ",
             sb.tally[hclc_pkg::OUT_HOT_HIT], sb.tally[hclc_pkg::OUT_COLD_HIT],
             sb.tally[hclc_pkg::OUT_MISS], sb.tally[hclc_pkg::OUT_QUERY],
             "ignored %0d, demotions %0d, evictions %0d",
             sb.tally[hclc_pkg::OUT_IGNORED], sb.demotions, sb.evictions);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: hot_cold_lru_classifier.f
+incdir+rtl
rtl/hclc_pkg.sv
rtl/hclc_pos_enc.sv
rtl/hclc_cell.sv
rtl/hot_cold_lru_classifier.sv
tb/sv/hclc_tb_pkg.sv
tb/sv/hot_cold_lru_classifier_tb.sv
